// ===== sv/stlc_pkg.sv =====
// Shared types and constants of the signal-tower light controller.
// No dependencies; used by stlc_timer, stlc_chan and the top level.
package stlc_pkg;

  localparam int CHANNELS = 6;
  localparam int NUM_OUT  = 6;
  localparam int LVL_W    = 8;
  localparam int TIMER_W  = 14;
  localparam int DATA_W   = 14;
  localparam int MASK_W   = 6;

  localparam logic [TIMER_W-1:0] TIME_MAX      = TIMER_W'(10000);
  localparam logic [TIMER_W-1:0] BLINK_MS_RST  = TIMER_W'(1000);
  localparam logic [TIMER_W-1:0] TIMEOUT_RST   = TIMER_W'(1000);
  localparam logic [MASK_W-1:0]  SLEEP_MASK_RST = MASK_W'(30);

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_CMD   = 2'd1,
    FUNC_SLEEP = 2'd2,
    FUNC_FLASH = 2'd3
  } func_t;

  // Stored channel mode
  typedef enum logic [1:0] {
    CM_NONE   = 2'd0,
    CM_STEADY = 2'd1,
    CM_FLASH  = 2'd2,
    CM_BLINK  = 2'd3
  } chan_mode_t;

  // Mode code carried by a channel command
  localparam logic [1:0] CMD_MODE_BAD = 2'd3;

  typedef enum logic [1:0] {
    REG_TOWER_MODE = 2'd0,
    REG_BLINK_MS   = 2'd1,
    REG_TIMEOUT_MS = 2'd2,
    REG_SLEEP_MASK = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic blink_phase;
    logic flash_phase;
    logic timed_out;
  } phase_t;

endpackage

// ===== sv/stlc_timer.sv =====
// Blink and flash-timeout counters with their phase bits.
// Depends on stlc_pkg.
module stlc_timer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  stlc_pkg::func_t               func,
  input  logic                          level,
  input  logic [stlc_pkg::TIMER_W-1:0]  blink_ms,
  input  logic [stlc_pkg::TIMER_W-1:0]  timeout_ms,
  output stlc_pkg::phase_t              ph_next
);

  stlc_pkg::phase_t             ph;
  logic [stlc_pkg::TIMER_W-1:0] blink_elapsed;
  logic [stlc_pkg::TIMER_W-1:0] flash_elapsed;
  logic [stlc_pkg::TIMER_W-1:0] blink_elapsed_next;
  logic [stlc_pkg::TIMER_W-1:0] flash_elapsed_next;
  logic [stlc_pkg::TIMER_W-1:0] blink_inc;
  logic [stlc_pkg::TIMER_W-1:0] flash_inc;

  // Saturating increments
  assign blink_inc = (&blink_elapsed) ? blink_elapsed : blink_elapsed + 1'b1;
  assign flash_inc = (&flash_elapsed) ? flash_elapsed : flash_elapsed + 1'b1;

  always_comb begin
    ph_next            = ph;
    blink_elapsed_next = blink_elapsed;
    flash_elapsed_next = flash_elapsed;
    if (accept) begin
      case (func)
        stlc_pkg::FUNC_TICK: begin
          blink_elapsed_next = blink_inc;
          flash_elapsed_next = flash_inc;
          if (blink_inc > blink_ms) begin
            ph_next.blink_phase = ~ph.blink_phase;
            blink_elapsed_next  = '0;
          end
          if (flash_inc > timeout_ms) begin
            ph_next.timed_out  = 1'b1;
            flash_elapsed_next = '0;
          end
        end
        stlc_pkg::FUNC_FLASH: begin
          ph_next.flash_phase = level;
          ph_next.timed_out   = 1'b0;
          flash_elapsed_next  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph            <= '0;
      blink_elapsed <= '0;
      flash_elapsed <= '0;
    end else begin
      ph            <= ph_next;
      blink_elapsed <= blink_elapsed_next;
      flash_elapsed <= flash_elapsed_next;
    end
  end

endmodule

// ===== sv/stlc_chan.sv =====
// Per-channel mode and brightness store and the drive-value logic.
// Depends on stlc_pkg.
module stlc_chan (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd,
  input  logic [2:0]                   channel,
  input  logic                         set_mode,
  input  logic [1:0]                   mode,
  input  logic                         set_brightness,
  input  logic [stlc_pkg::LVL_W-1:0]   brightness,
  input  logic                         tower_mode,
  input  logic                         clear_levels,
  input  stlc_pkg::phase_t             ph_next,
  input  logic                         asleep_next,
  input  logic [stlc_pkg::MASK_W-1:0]  sleep_mask,
  output logic [stlc_pkg::LVL_W-1:0]   drive [stlc_pkg::CHANNELS]
);

  stlc_pkg::chan_mode_t       chan_mode      [stlc_pkg::CHANNELS];
  stlc_pkg::chan_mode_t       chan_mode_next [stlc_pkg::CHANNELS];
  logic [stlc_pkg::LVL_W-1:0] chan_level      [stlc_pkg::CHANNELS];
  logic [stlc_pkg::LVL_W-1:0] chan_level_next [stlc_pkg::CHANNELS];
  logic [stlc_pkg::CHANNELS-1:0] dark_mask;
  logic ch_ok;
  logic cmd_ok;
  logic wipe_others;

  // Sleep only reaches the reported channels
  for (genvar g = 0; g < stlc_pkg::CHANNELS; g++) begin : g_mask
    if (g < stlc_pkg::NUM_OUT && g < stlc_pkg::MASK_W) begin : g_on
      assign dark_mask[g] = sleep_mask[g];
    end else begin : g_off
      assign dark_mask[g] = 1'b0;
    end
  end

  assign ch_ok  = (int'(channel) >= 1) && (int'(channel) <= stlc_pkg::CHANNELS);
  assign cmd_ok = cmd && ch_ok && !(set_mode && (mode == stlc_pkg::CMD_MODE_BAD));
  assign wipe_others = cmd_ok && set_brightness && !tower_mode
                       && (int'(channel) != stlc_pkg::CHANNELS);

  always_comb begin
    for (int x = 0; x < stlc_pkg::CHANNELS; x++) begin
      chan_mode_next[x]  = chan_mode[x];
      chan_level_next[x] = chan_level[x];
      if (clear_levels) begin
        chan_level_next[x] = '0;
      end
      if (wipe_others && (x < stlc_pkg::CHANNELS - 1)) begin
        chan_level_next[x] = '0;
      end
      if (cmd_ok && (int'(channel) == x + 1)) begin
        if (set_mode) begin
          chan_mode_next[x] = stlc_pkg::chan_mode_t'(mode + 2'd1);
        end
        if (set_brightness) begin
          chan_level_next[x] = brightness;
        end
      end
    end
  end

  always_comb begin
    for (int x = 0; x < stlc_pkg::CHANNELS; x++) begin
      logic on;
      case (chan_mode_next[x])
        stlc_pkg::CM_STEADY: on = 1'b1;
        stlc_pkg::CM_FLASH:  on = ph_next.timed_out ? ph_next.blink_phase
                                                    : ph_next.flash_phase;
        stlc_pkg::CM_BLINK:  on = ph_next.blink_phase;
        default:             on = 1'b0;
      endcase
      if (asleep_next && dark_mask[x]) begin
        on = 1'b0;
      end
      drive[x] = on ? chan_level_next[x] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int x = 0; x < stlc_pkg::CHANNELS; x++) begin
        chan_mode[x]  <= stlc_pkg::CM_NONE;
        chan_level[x] <= '0;
      end
    end else begin
      for (int x = 0; x < stlc_pkg::CHANNELS; x++) begin
        chan_mode[x]  <= chan_mode_next[x];
        chan_level[x] <= chan_level_next[x];
      end
    end
  end

endmodule

// ===== sv/signal_tower_led_channel_controller_core.sv =====
// Result timing: the drive values for an accepted beat appear on the output
//   register in the next cycle. Throughput: one beat per cycle, set by the
//   single result register, which frees whenever it is taken.
// Reset (rst, synchronous): all channels mode none and dark, phases and
//   counters zero, awake; tower_mode 0, blink_ms and timeout_ms 1000,
//   sleep_mask 30. Depends on stlc_pkg, stlc_timer, stlc_chan.
module signal_tower_led_channel_controller_core (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  // input beat
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [2:0]  channel,
  input  logic        set_mode,
  input  logic [1:0]  mode,
  input  logic        set_brightness,
  input  logic [7:0]  brightness,
  input  logic        level,
  // result beat
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_ch1,
  output logic [7:0]  out_ch2,
  output logic [7:0]  out_ch3,
  output logic [7:0]  out_ch4,
  output logic [7:0]  out_ch5,
  output logic [7:0]  out_ch6
);

  // Configuration registers
  logic                          tower_mode;
  logic [stlc_pkg::TIMER_W-1:0]  blink_ms;
  logic [stlc_pkg::TIMER_W-1:0]  timeout_ms;
  logic [stlc_pkg::MASK_W-1:0]   sleep_mask;
  logic [stlc_pkg::TIMER_W-1:0]  cfg_time;
  logic                          clear_levels;

  // Item state
  logic                          asleep;
  logic                          asleep_next;
  logic                          accept;
  stlc_pkg::func_t               func_q;
  stlc_pkg::phase_t              ph_next;
  logic [stlc_pkg::LVL_W-1:0]    drive     [stlc_pkg::CHANNELS];
  logic [stlc_pkg::LVL_W-1:0]    out_drive [stlc_pkg::NUM_OUT];
  logic [stlc_pkg::LVL_W-1:0]    out_q     [stlc_pkg::NUM_OUT];

  // The result register parts the two sides: take a new beat whenever the
  // current result is gone or leaving this cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign func_q   = stlc_pkg::func_t'(func);

  // Clamp timing writes to the legal range
  assign cfg_time = (cfg_data > stlc_pkg::TIME_MAX) ? stlc_pkg::TIME_MAX : cfg_data;

  // Any tower_mode write wipes every brightness
  assign clear_levels = cfg_we && (cfg_index == stlc_pkg::REG_TOWER_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      tower_mode <= 1'b0;
      blink_ms   <= stlc_pkg::BLINK_MS_RST;
      timeout_ms <= stlc_pkg::TIMEOUT_RST;
      sleep_mask <= stlc_pkg::SLEEP_MASK_RST;
    end else if (cfg_we) begin
      case (stlc_pkg::reg_idx_t'(cfg_index))
        stlc_pkg::REG_TOWER_MODE: tower_mode <= cfg_data[0];
        stlc_pkg::REG_BLINK_MS:   blink_ms   <= cfg_time;
        stlc_pkg::REG_TIMEOUT_MS: timeout_ms <= cfg_time;
        stlc_pkg::REG_SLEEP_MASK: sleep_mask <= cfg_data[stlc_pkg::MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sleep flag follows sleep commands
  assign asleep_next = (accept && (func_q == stlc_pkg::FUNC_SLEEP)) ? level : asleep;

  always_ff @(posedge clk) begin
    if (rst) begin
      asleep <= 1'b0;
    end else begin
      asleep <= asleep_next;
    end
  end

  stlc_timer u_timer (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .func       (func_q),
    .level      (level),
    .blink_ms   (blink_ms),
    .timeout_ms (timeout_ms),
    .ph_next    (ph_next)
  );

  stlc_chan u_chan (
    .clk            (clk),
    .rst            (rst),
    .cmd            (accept && (func_q == stlc_pkg::FUNC_CMD)),
    .channel        (channel),
    .set_mode       (set_mode),
    .mode           (mode),
    .set_brightness (set_brightness),
    .brightness     (brightness),
    .tower_mode     (tower_mode),
    .clear_levels   (clear_levels),
    .ph_next        (ph_next),
    .asleep_next    (asleep_next),
    .sleep_mask     (sleep_mask),
    .drive          (drive)
  );

  // Report slots beyond the channel count read zero
  for (genvar j = 0; j < stlc_pkg::NUM_OUT; j++) begin : g_out
    if (j < stlc_pkg::CHANNELS) begin : g_used
      assign out_drive[j] = drive[j];
    end else begin : g_unused
      assign out_drive[j] = '0;
    end
  end

  // Result register: load on accept, hold while stalled, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < stlc_pkg::NUM_OUT; j++) begin
        out_q[j] <= out_drive[j];
      end
    end
  end

  assign out_ch1 = out_q[0];
  assign out_ch2 = out_q[1];
  assign out_ch3 = out_q[2];
  assign out_ch4 = out_q[3];
  assign out_ch5 = out_q[4];
  assign out_ch6 = out_q[5];

  // Every accepted beat leaves a result behind
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  // A flash command always ends the timeout fallback
  a_flash_clears_timeout: assert property (@(posedge clk) disable iff (rst)
    (accept && (func_q == stlc_pkg::FUNC_FLASH)) |-> !ph_next.timed_out)
    else $error("flash command left timeout raised");

  // Timing registers never hold a value above the clamp
  a_timing_clamped: assert property (@(posedge clk) disable iff (rst)
    (blink_ms <= stlc_pkg::TIME_MAX) && (timeout_ms <= stlc_pkg::TIME_MAX))
    else $error("timing register above limit");

  // A sleep command on a masked channel leaves it dark
  a_sleep_darkens: assert property (@(posedge clk) disable iff (rst)
    (accept && (func_q == stlc_pkg::FUNC_SLEEP) && level && sleep_mask[0])
      |=> (out_ch1 == '0))
    else $error("masked channel lit while asleep");

endmodule

// ===== tb/tower_drive_checker.sv =====
// Scoreboard for the signal-tower light controller: tracks config writes,
// predicts the six drive values of every input beat and compares result beats.
// Depends on stlc_pkg for widths, function codes, channel modes and register indexes.
module tower_drive_checker
  import stlc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        func,
  input  logic [2:0]        channel,
  input  logic              set_mode,
  input  logic [1:0]        mode,
  input  logic              set_brightness,
  input  logic [7:0]        brightness,
  input  logic              level,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        out_ch1,
  input  logic [7:0]        out_ch2,
  input  logic [7:0]        out_ch3,
  input  logic [7:0]        out_ch4,
  input  logic [7:0]        out_ch5,
  input  logic [7:0]        out_ch6,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [NUM_OUT-1:0][LVL_W-1:0] drive_t;

  // shadow of the configuration registers
  logic               tower_multi;
  logic [TIMER_W-1:0] blink_lim;
  logic [TIMER_W-1:0] timeout_lim;
  logic [MASK_W-1:0]  dark_mask;

  // shadow of the lamp state
  chan_mode_t         lamp_mode  [CHANNELS];
  logic [LVL_W-1:0]   lamp_level [CHANNELS];
  logic               blink_ph;
  logic               flash_ph;
  logic               flash_lost;
  logic               sleeping;
  logic [TIMER_W-1:0] blink_cnt;
  logic [TIMER_W-1:0] flash_cnt;

  drive_t drives_due[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic void clear_lamps();
    for (int i = 0; i < CHANNELS; i++) begin
      lamp_mode[i]  = CM_NONE;
      lamp_level[i] = '0;
    end
    tower_multi = 1'b0;
    blink_lim   = BLINK_MS_RST;
    timeout_lim = TIMEOUT_RST;
    dark_mask   = SLEEP_MASK_RST;
    blink_ph    = 1'b0;
    flash_ph    = 1'b0;
    flash_lost  = 1'b0;
    sleeping    = 1'b0;
    blink_cnt   = '0;
    flash_cnt   = '0;
  endfunction

  function automatic void write_reg(reg_idx_t idx, logic [DATA_W-1:0] d);
    case (idx)
      REG_TOWER_MODE: begin
        tower_multi = d[0];
        for (int i = 0; i < CHANNELS; i++) lamp_level[i] = '0;
      end
      REG_BLINK_MS:   blink_lim   = (d > TIME_MAX) ? TIME_MAX : d;
      REG_TIMEOUT_MS: timeout_lim = (d > TIME_MAX) ? TIME_MAX : d;
      default:        dark_mask   = d[MASK_W-1:0];
    endcase
  endfunction

  function automatic void apply_beat(func_t f, logic [2:0] ch, logic sm, logic [1:0] md,
                                     logic sb, logic [7:0] br, logic lv);
    int idx;
    idx = int'(ch) - 1;
    case (f)
      FUNC_TICK: begin
        if (blink_cnt != '1) blink_cnt++;
        if (flash_cnt != '1) flash_cnt++;
        if (blink_cnt > blink_lim) begin
          blink_ph  = ~blink_ph;
          blink_cnt = '0;
        end
        if (flash_cnt > timeout_lim) begin
          flash_lost = 1'b1;
          flash_cnt  = '0;
        end
      end
      FUNC_CMD: begin
        // drop bad channels and bad modes, brightness included
        if (ch != 3'd0 && int'(ch) <= CHANNELS && !(sm && md == CMD_MODE_BAD)) begin
          if (sm) lamp_mode[idx] = chan_mode_t'(md + 2'd1);
          if (sb) begin
            if (idx != CHANNELS - 1 && !tower_multi) begin
              for (int x = 0; x < CHANNELS - 1; x++) lamp_level[x] = '0;
            end
            lamp_level[idx] = br;
          end
        end
      end
      FUNC_SLEEP: sleeping = lv;
      default: begin
        flash_ph   = lv;
        flash_lost = 1'b0;
        flash_cnt  = '0;
      end
    endcase
  endfunction

  function automatic drive_t drive_values();
    drive_t d;
    logic   on;
    d = '0;
    for (int i = 0; i < CHANNELS && i < NUM_OUT; i++) begin
      case (lamp_mode[i])
        CM_STEADY: on = 1'b1;
        CM_FLASH:  on = flash_lost ? blink_ph : flash_ph;
        CM_BLINK:  on = blink_ph;
        default:   on = 1'b0;
      endcase
      if (sleeping && i < MASK_W && dark_mask[i]) on = 1'b0;
      d[i] = on ? lamp_level[i] : '0;
    end
    return d;
  endfunction

  always @(posedge clk) begin
    drive_t got;
    drive_t want;
    got = {out_ch6, out_ch5, out_ch4, out_ch3, out_ch2, out_ch1};
    if (rst) begin
      clear_lamps();
      drives_due.delete();
    end else begin
      // compare the result beat before the input beat of this edge is added
      if (out_valid && out_ready) begin
        if (drives_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: got %h", got);
        end else begin
          want = drives_due.pop_front();
          for (int i = 0; i < NUM_OUT; i++) begin
            if (got[i] !== want[i]) begin
              errors++;
              if (errors <= 10)
                $display("out_ch%0d mismatch: expected %0d, got %0d", i + 1, want[i], got[i]);
            end
          end
        end
      end
      if (cfg_we) write_reg(reg_idx_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) begin
        apply_beat(func_t'(func), channel, set_mode, mode, set_brightness, brightness, level);
        drives_due.push_back(drive_values());
      end
    end
    pending = drives_due.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the light controller testbench: clock, reset, stimulus and verdict.
// Depends on stlc_pkg, signal_tower_led_channel_controller_core and tower_drive_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import stlc_pkg::*;

  // Cycles without any accepted beat before the run is declared hung. The
  // longest legal quiet stretch is the receiver hold-off below.
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASES       = 8;
  localparam int PHASE_BEATS  = 168;

  typedef struct packed {
    func_t      func;
    logic [2:0] channel;
    logic       set_mode;
    logic [1:0] mode;
    logic       set_brightness;
    logic [7:0] brightness;
    logic       level;
  } beat_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [DATA_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        func;
  logic [2:0]        channel;
  logic              set_mode;
  logic [1:0]        mode;
  logic              set_brightness;
  logic [7:0]        brightness;
  logic              level;
  logic              out_valid;
  logic              out_ready;
  logic [7:0]        out_ch1, out_ch2, out_ch3, out_ch4, out_ch5, out_ch6;

  int errors;
  int pending;
  int sent;          // input beats accepted so far
  int quiet;         // cycles since the last accepted beat
  int sender_idle_pct;
  int recv_stall_pct;
  bit hold_req;

  // per-phase settings; the idle pattern cycles through four styles
  int sender_pct [4] = '{0, 58, 0, 38};
  int recv_pct   [4] = '{0, 0, 58, 38};
  int tower_tab  [PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0};
  int blink_tab  [PHASES] = '{0, 10000, 1, 3, 16383, 2, 5, 7};
  int tmo_tab    [PHASES] = '{0, 1, 10000, 2, 12000, 4, 3, 16383};
  int mask_tab   [PHASES] = '{63, 0, 30, 21, 42, 1, 32, 63};

  always #6 clk = ~clk;

  signal_tower_led_channel_controller_core dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .func, .channel, .set_mode, .mode,
    .set_brightness, .brightness, .level,
    .out_valid, .out_ready,
    .out_ch1, .out_ch2, .out_ch3, .out_ch4, .out_ch5, .out_ch6
  );

  tower_drive_checker drive_check (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .func, .channel, .set_mode, .mode,
    .set_brightness, .brightness, .level,
    .out_valid, .out_ready,
    .out_ch1, .out_ch2, .out_ch3, .out_ch4, .out_ch5, .out_ch6,
    .errors, .pending
  );

  // Count accepted input beats; the sender watches this at the falling edge.
  always @(posedge clk) begin
    if (rst) begin
      sent <= 0;
    end else if (in_valid && in_ready) begin
      sent <= sent + 1;
    end
  end

  // Watchdog: any accepted beat on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: stall at random, or hold off for a long stretch on request so
  // that the result register fills and the block stalls its input.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic beat_t mk_beat(func_t f, logic [2:0] ch, logic sm, logic [1:0] md,
                                    logic sb, logic [7:0] br, logic lv);
    beat_t b;
    b.func           = f;
    b.channel        = ch;
    b.set_mode       = sm;
    b.mode           = md;
    b.set_brightness = sb;
    b.brightness     = br;
    b.level          = lv;
    return b;
  endfunction

  // Mostly well-formed beats with random content; unused fields stay random
  // and the tail of the distribution is pure noise (bad channels, bad modes).
  function automatic beat_t random_beat();
    beat_t b;
    int    pick;
    b.func           = func_t'($urandom_range(3));
    b.channel        = 3'($urandom_range(7));
    b.set_mode       = 1'($urandom_range(1));
    b.mode           = 2'($urandom_range(3));
    b.set_brightness = 1'($urandom_range(1));
    b.brightness     = 8'($urandom_range(255));
    b.level          = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 35) begin
      b.func = FUNC_TICK;
    end else if (pick < 78) begin
      b.func           = FUNC_CMD;
      b.channel        = 3'($urandom_range(CHANNELS, 1));
      b.mode           = 2'($urandom_range(2));
      b.set_brightness = ($urandom_range(3) != 0);
      case ($urandom_range(7))
        0: b.brightness = 8'h00;
        1: b.brightness = 8'hFF;
        default: ;
      endcase
    end else if (pick < 85) begin
      b.func = FUNC_SLEEP;
    end else if (pick < 92) begin
      b.func = FUNC_FLASH;
    end
    return b;
  endfunction

  // Offer one beat and hold it until accepted. Called at a falling edge.
  task automatic drive_beat(input beat_t b);
    int target;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    target = sent + 1;
    in_valid       <= 1'b1;
    func           <= b.func;
    channel        <= b.channel;
    set_mode       <= b.set_mode;
    mode           <= b.mode;
    set_brightness <= b.set_brightness;
    brightness     <= b.brightness;
    level          <= b.level;
    do @(negedge clk); while (sent != target);
  endtask

  // Drop valid and wait until every result beat has come out.
  // Called at a falling edge.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [DATA_W-1:0] upper;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = REG_TOWER_MODE;
    cfg_data        = '0;
    in_valid        = 1'b0;
    func            = FUNC_TICK;
    channel         = '0;
    set_mode        = 1'b0;
    mode            = '0;
    set_brightness  = 1'b0;
    brightness      = '0;
    level           = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_req        = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed beats at reset settings: single tower, mask darkens 2..5.
    drive_beat(mk_beat(FUNC_TICK,  3'd7, 1'b1, 2'd3, 1'b1, 8'hFF, 1'b1));  // junk in unused fields
    drive_beat(mk_beat(FUNC_CMD,   3'd1, 1'b1, 2'd0, 1'b1, 8'hFF, 1'b0));  // ch1 steady full
    drive_beat(mk_beat(FUNC_CMD,   3'd6, 1'b1, 2'd0, 1'b1, 8'hFF, 1'b0));  // last channel keeps others
    drive_beat(mk_beat(FUNC_CMD,   3'd2, 1'b1, 2'd0, 1'b1, 8'h80, 1'b0));  // single tower clears ch1
    drive_beat(mk_beat(FUNC_CMD,   3'd0, 1'b1, 2'd0, 1'b1, 8'h63, 1'b0));  // channel zero ignored
    drive_beat(mk_beat(FUNC_CMD,   3'd7, 1'b1, 2'd0, 1'b1, 8'h63, 1'b1));  // channel above range ignored
    drive_beat(mk_beat(FUNC_CMD,   3'd3, 1'b1, CMD_MODE_BAD, 1'b1, 8'h4D, 1'b0)); // bad mode drops all
    drive_beat(mk_beat(FUNC_CMD,   3'd3, 1'b1, 2'd1, 1'b1, 8'hC8, 1'b0));  // ch3 flash
    drive_beat(mk_beat(FUNC_FLASH, 3'd0, 1'b0, 2'd0, 1'b0, 8'h00, 1'b1));
    drive_beat(mk_beat(FUNC_FLASH, 3'd5, 1'b1, 2'd2, 1'b1, 8'h11, 1'b0));
    drive_beat(mk_beat(FUNC_CMD,   3'd4, 1'b1, 2'd2, 1'b0, 8'h37, 1'b0));  // mode only, blink
    drive_beat(mk_beat(FUNC_CMD,   3'd4, 1'b0, CMD_MODE_BAD, 1'b1, 8'h01, 1'b1)); // mode absent, ok
    drive_beat(mk_beat(FUNC_SLEEP, 3'd2, 1'b0, 2'd0, 1'b0, 8'h00, 1'b1));
    drive_beat(mk_beat(FUNC_CMD,   3'd6, 1'b1, 2'd0, 1'b1, 8'hAA, 1'b0));
    drive_beat(mk_beat(FUNC_SLEEP, 3'd6, 1'b1, 2'd1, 1'b1, 8'hFF, 1'b0));
    drive_beat(mk_beat(FUNC_CMD,   3'd5, 1'b1, 2'd0, 1'b1, 8'hFF, 1'b0));
    drive_beat(mk_beat(FUNC_CMD,   3'd5, 1'b0, 2'd0, 1'b0, 8'h00, 1'b1));  // nothing carried
    drive_beat(mk_beat(FUNC_CMD,   3'd1, 1'b1, 2'd0, 1'b1, 8'h00, 1'b0));  // zero brightness
    drive_beat(mk_beat(FUNC_FLASH, 3'd7, 1'b1, 2'd3, 1'b1, 8'hFF, 1'b1));
    drive_beat(mk_beat(FUNC_TICK,  3'd0, 1'b0, 2'd0, 1'b0, 8'h00, 1'b0));
    drive_beat(mk_beat(FUNC_SLEEP, 3'd7, 1'b1, 2'd3, 1'b1, 8'hFF, 1'b1));

    // Random phases, each with its own register settings and idle pattern.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      upper = DATA_W'($urandom_range(8191)) << 1;
      cfg_write(REG_TOWER_MODE, upper | DATA_W'(tower_tab[p]));
      cfg_write(REG_BLINK_MS,   DATA_W'(blink_tab[p]));
      cfg_write(REG_TIMEOUT_MS, DATA_W'(tmo_tab[p]));
      upper = DATA_W'($urandom_range(255)) << MASK_W;
      cfg_write(REG_SLEEP_MASK, upper | DATA_W'(mask_tab[p]));
      @(negedge clk);
      sender_idle_pct = sender_pct[p % 4];
      recv_stall_pct  = recv_pct[p % 4];
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // in phases without sender gaps or receiver stalls, hold the receiver off once early on
        if (n == 40 && sender_idle_pct == 0 && recv_stall_pct == 0) hold_req = 1'b1;
        drive_beat(random_beat());
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
